[design/spfd_pkg.sv]
// spfd_pkg: shared types and constants of the space packet frame decoder
// no dependencies; imported by the top, spfd_in_stage and spfd_decode
package spfd_pkg;

   localparam int unsigned COUNT_W = 17;

   localparam logic [COUNT_W-1:0] HEADER_LEN = 17'd8;
   localparam logic [COUNT_W-1:0] MIN_FRAME  = 17'd11;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 17'h1FFFF;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_SHORT    = 3'd1,
      ST_ID_ERR   = 3'd2,
      ST_LEN_ERR  = 3'd3,
      ST_SUM_ERR  = 3'd4
   } status_type;

   // one registered input byte handed from the input stage to the decoder
   typedef struct packed {
      logic       valid;
      logic [7:0] byte_in;
      logic       last;
   } beat_type;

endpackage

[design/spfd_if.sv]
// spfd_if: valid/ready channel interfaces for request, response and csr write
// no dependencies
interface spfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       last;

   modport source (output valid, output byte_in, output last, input ready);
   modport sink   (input valid, input byte_in, input last, output ready);
endinterface

interface spfd_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  payload_byte;
   logic        end_of_run;
   logic [2:0]  status;
   logic [2:0]  version;
   logic        packet_type;
   logic        secondary_flag;
   logic [10:0] application_id;
   logic [1:0]  grouping;
   logic [13:0] sequence_count;
   logic [15:0] length_field;

   modport source (output valid, output kind, output payload_byte, output end_of_run,
                   output status, output version, output packet_type,
                   output secondary_flag, output application_id, output grouping,
                   output sequence_count, output length_field, input ready);
   modport sink   (input valid, input kind, input payload_byte, input end_of_run,
                   input status, input version, input packet_type,
                   input secondary_flag, input application_id, input grouping,
                   input sequence_count, input length_field, output ready);
endinterface

interface spfd_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] frame_identifier;

   modport source (output valid, output frame_identifier, input ready);
   modport sink   (input valid, input frame_identifier, output ready);
endinterface

[design/space_packet_frame_decoder_top.sv]
// space_packet_frame_decoder_top: byte-wise space packet deframer with checks
// depends on spfd_pkg, spfd_if, spfd_in_stage and spfd_decode
//
//   port     dir   contents
//   req_ch   sink  byte_in, last
//   rsp_ch   src   kind, payload_byte, end_of_run, status, header fields
//   csr_ch   sink  frame_identifier
//
// one byte per cycle unless rsp_ch stalls; results pass input and result registers
// the frame state update is a registered loop in the decode stage
// reset clears the frame state, the identifier and both valid flags
// a stalled response holds the decode stage; the input register takes one more byte
// and the request channel then stalls until the response moves
module space_packet_frame_decoder_top
   import spfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   spfd_req_if.sink   req_ch,
   spfd_rsp_if.source rsp_ch,
   spfd_csr_if.sink   csr_ch
);

   beat_type beat;
   logic     advance;

   spfd_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .advance (advance),
      .beat    (beat)
   );

   spfd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .beat    (beat),
      .advance (advance),
      .rsp_ch  (rsp_ch),
      .csr_ch  (csr_ch)
   );

endmodule

[design/spfd_in_stage.sv]
// spfd_in_stage: input register of the decoder, one byte deep
// depends on spfd_pkg and spfd_req_if
module spfd_in_stage
   import spfd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   spfd_req_if.sink  req_ch,
   input  logic      advance,
   output beat_type  beat
);

   logic       valid_ff;
   logic [7:0] byte_ff;
   logic       last_ff;

   assign req_ch.ready = !valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ch.valid && req_ch.ready) begin
         valid_ff <= 1'b1;
      end else if (advance) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         byte_ff <= req_ch.byte_in;
         last_ff <= req_ch.last;
      end
   end

   assign beat.valid   = valid_ff;
   assign beat.byte_in = byte_ff;
   assign beat.last    = last_ff;

endmodule

[design/spfd_decode.sv]
// spfd_decode: frame state, header parse, checks and the result register
// depends on spfd_pkg, spfd_rsp_if and spfd_csr_if
module spfd_decode
   import spfd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  beat_type  beat,
   output logic      advance,
   spfd_rsp_if.source rsp_ch,
   spfd_csr_if.sink   csr_ch
);

   logic [15:0]        frame_id_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [63:0]        header_ff, header_in;
   logic [15:0]        sum_ff, sum_in;
   logic [15:0]        trail_ff, trail_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               kind_ff, kind_in;
   logic [7:0]         pbyte_ff, pbyte_in;
   status_type         status_ff, status_in;
   logic [63:0]        rhdr_ff, rhdr_in;

   logic               is_header;
   logic               is_payload;
   logic [COUNT_W-1:0] payload_end;
   logic               step;

   assign csr_ch.ready = 1'b1;
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign step         = advance && beat.valid;

   always_comb begin
      is_header   = count_ff < HEADER_LEN;
      payload_end = HEADER_LEN + {1'b0, header_ff[15:0]};
      is_payload  = !is_header && (count_ff != COUNT_MAX) && (count_ff <= payload_end);

      header_in = is_header ? {header_ff[55:0], beat.byte_in} : header_ff;
      trail_in  = is_header ? trail_ff : {trail_ff[7:0], beat.byte_in};
      sum_in    = (is_header || is_payload) ? sum_ff + {8'd0, beat.byte_in} : sum_ff;
      count_in  = (count_ff == COUNT_MAX) ? count_ff : count_ff + 17'd1;

      if (count_in < MIN_FRAME) begin
         status_in = ST_SHORT;
      end else if (header_in[63:48] != frame_id_ff) begin
         status_in = ST_ID_ERR;
      end else if (count_in != {1'b0, header_in[15:0]} + MIN_FRAME) begin
         status_in = ST_LEN_ERR;
      end else if (sum_in != trail_in) begin
         status_in = ST_SUM_ERR;
      end else begin
         status_in = ST_OK;
      end
   end

   always_comb begin
      rsp_valid_in = 1'b0;
      kind_in      = KIND_PAYLOAD;
      pbyte_in     = 8'd0;
      rhdr_in      = 64'd0;
      if (beat.last) begin
         rsp_valid_in = 1'b1;
         kind_in      = KIND_STATUS;
         rhdr_in      = header_in;
      end else if (is_payload) begin
         rsp_valid_in = 1'b1;
         pbyte_in     = beat.byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_id_ff <= 16'd0;
      end else if (csr_ch.valid && csr_ch.ready) begin
         frame_id_ff <= csr_ch.frame_identifier;
      end
   end

   // frame state, cleared again after the closing byte
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         header_ff <= 64'd0;
         sum_ff    <= 16'd0;
         trail_ff  <= 16'd0;
      end else if (step) begin
         if (beat.last) begin
            count_ff  <= '0;
            header_ff <= 64'd0;
            sum_ff    <= 16'd0;
            trail_ff  <= 16'd0;
         end else begin
            count_ff  <= count_in;
            header_ff <= header_in;
            sum_ff    <= sum_in;
            trail_ff  <= trail_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= beat.valid && rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         kind_ff   <= kind_in;
         pbyte_ff  <= pbyte_in;
         status_ff <= beat.last ? status_in : ST_OK;
         rhdr_ff   <= rhdr_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.kind           = kind_ff;
   assign rsp_ch.payload_byte   = pbyte_ff;
   assign rsp_ch.end_of_run     = kind_ff;
   assign rsp_ch.status         = status_ff;
   assign rsp_ch.version        = rhdr_ff[47:45];
   assign rsp_ch.packet_type    = rhdr_ff[44];
   assign rsp_ch.secondary_flag = rhdr_ff[43];
   assign rsp_ch.application_id = rhdr_ff[42:32];
   assign rsp_ch.grouping       = rhdr_ff[31:30];
   assign rsp_ch.sequence_count = rhdr_ff[29:16];
   assign rsp_ch.length_field   = rhdr_ff[15:0];

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (step && beat.last) |=> (count_ff == '0 && sum_ff == 16'd0 && trail_ff == 16'd0))
      else $error("frame state not cleared after closing byte");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (step && !beat.last) |=> (count_ff != '0 && count_ff >= $past(count_ff)))
      else $error("byte count went backwards mid-frame");

   a_header_silent: assert property (@(posedge clock) disable iff (reset)
      (step && !beat.last && count_ff < HEADER_LEN) |=> !rsp_valid_ff)
      else $error("header byte produced a result");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff == KIND_PAYLOAD) |-> (status_ff == ST_OK && rhdr_ff == 64'd0))
      else $error("payload result carries status fields");

endmodule
